>>> rtl/bps_pkg.sv
// Shared widths, types and codes for the Blinn-Phong specular term block.
// Used by bps_alu, bps_ctrl and blinn_phong_specular_term; no dependencies.
package bps_pkg;

	localparam int COMPONENT_BITS = 16;
	localparam int EXPONENT_BITS  = 8;

	localparam int H_SHIFT = (COMPONENT_BITS > 20) ? COMPONENT_BITS - 20 : 0;
	localparam int H_W     = COMPONENT_BITS + 1 - H_SHIFT;
	localparam int N_W     = COMPONENT_BITS;
	localparam int MA_W    = (H_W > 17) ? H_W : 17;
	localparam int MB_W    = (N_W > MA_W) ? N_W : MA_W;
	localparam int PROD_W  = MA_W + MB_W;
	localparam int DOT_W   = H_W + N_W + 2;

	localparam int NORM_W  = 62;
	localparam int ROOT_W  = 31;
	localparam int REM_W   = ROOT_W + 3;
	localparam int Q_W     = 16;
	localparam int DV_W    = NORM_W - 17 + COMPONENT_BITS;
	localparam int E_OFF   = 17 - COMPONENT_BITS;
	localparam int CNT_W   = 5;

	localparam int Q15_SHIFT = 15;
	localparam int ROUND_Q15 = 16384;

	typedef logic signed [COMPONENT_BITS-1:0] comp_t;
	typedef logic signed [H_W-1:0]            half_t;
	typedef logic [EXPONENT_BITS-1:0]         expo_t;
	typedef logic [Q_W-1:0]                   q15_t;

	localparam q15_t ONE_Q15 = q15_t'(32768);

	typedef enum logic {
		ALU_MUL = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t                  op;
		logic signed [MA_W-1:0]   mul_a;
		logic signed [MB_W-1:0]   mul_b;
		logic [REM_W-1:0]         sub_a;
		logic [REM_W-1:0]         sub_b;
	} alu_req_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic [REM_W-1:0]         diff;
		logic                     borrow;
	} alu_rsp_t;

	typedef struct packed {
		logic start;
		logic res_ready;
	} core_ctl_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
		q15_t res;
	} core_sts_t;

endpackage

>>> rtl/blinn_phong_specular_term.sv
// Blinn-Phong specular term, top level: input capture, half vector, result
// register and checks. Depends on bps_pkg, bps_alu and bps_ctrl.
//
// The input channel (in_valid, in_ready) takes one item: eye, light and
// normal directions in signed Q2.14 and an integer shininess exponent. The
// output channel (out_valid, out_ready) returns one item per input item:
// the specular term in unsigned Q1.15, where 32768 is 1.0.
// The block works on one item at a time and drops in_ready from acceptance
// until the result has moved into the output register. The steps are:
// multiplies for the squared half-vector length and the dot product, two bits
// of square normalization per cycle, one root bit per cycle (31-bit root),
// one quotient bit per cycle (16-bit quotient), and one or two multiplies
// per exponent bit. All of these share one multiplier and one
// subtractor.
// A result that waits in the output register does not stop the next item
// from being accepted; it only holds the block once its own next result is
// ready. Reset clears out_valid and returns the block to idle.
module blinn_phong_specular_term (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bps_pkg::comp_t eye_x,
	input  bps_pkg::comp_t eye_y,
	input  bps_pkg::comp_t eye_z,
	input  bps_pkg::comp_t light_x,
	input  bps_pkg::comp_t light_y,
	input  bps_pkg::comp_t light_z,
	input  bps_pkg::comp_t normal_x,
	input  bps_pkg::comp_t normal_y,
	input  bps_pkg::comp_t normal_z,
	input  bps_pkg::expo_t shininess,
	output logic           out_valid,
	input  logic           out_ready,
	output bps_pkg::q15_t  specular
);
	import bps_pkg::*;

	function automatic half_t half_comp(input comp_t l, input comp_t e);
		logic signed [COMPONENT_BITS:0] d;
		logic [COMPONENT_BITS:0]        mag;
		d   = (COMPONENT_BITS + 1)'(l) - (COMPONENT_BITS + 1)'(e);
		mag = d[COMPONENT_BITS] ? $unsigned(-d) : $unsigned(d);
		mag = mag >> H_SHIFT;
		half_comp = d[COMPONENT_BITS] ? -half_t'(mag) : half_t'(mag);
	endfunction

	half_t     h_q [3];
	comp_t     n_q [3];
	expo_t     expo_q;
	logic      out_valid_q;
	q15_t      specular_q;
	logic      accept;
	core_ctl_t core_ctl;
	core_sts_t core_sts;
	alu_req_t  alu_req;
	alu_rsp_t  alu_rsp;

	assign in_ready = core_sts.idle;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			h_q[0] <= half_comp(light_x, eye_x);
			h_q[1] <= half_comp(light_y, eye_y);
			h_q[2] <= half_comp(light_z, eye_z);
			n_q[0] <= normal_x;
			n_q[1] <= normal_y;
			n_q[2] <= normal_z;
			expo_q <= shininess;
		end
	end

	assign core_ctl.start     = accept;
	assign core_ctl.res_ready = !out_valid_q || out_ready;

	bps_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (core_ctl),
		.sts     (core_sts),
		.h_vec   (h_q),
		.n_vec   (n_q),
		.expo    (expo_q),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);

	bps_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_sts.res_valid && core_ctl.res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_sts.res_valid && core_ctl.res_ready) begin
			specular_q <= core_sts.res;
		end
	end

	assign out_valid = out_valid_q;
	assign specular  = specular_q;

	a_busy_after_accept: assert property (
		@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready
	) else $error("block stayed ready after taking an item");

	a_result_handoff: assert property (
		@(posedge clk) disable iff (!arst_n)
		core_sts.res_valid && core_ctl.res_ready |=>
			out_valid && in_ready && (specular == $past(core_sts.res))
	) else $error("finished item did not reach the output register");

	a_result_range: assert property (
		@(posedge clk) disable iff (!arst_n)
		core_sts.res_valid |-> (core_sts.res <= ONE_Q15)
	) else $error("specular term above one");

	a_no_finish_when_idle: assert property (
		@(posedge clk) disable iff (!arst_n)
		in_ready |-> !core_sts.res_valid
	) else $error("result offered while idle");

endmodule

>>> rtl/bps_alu.sv
// Shared arithmetic unit: one signed multiplier and one unsigned subtractor.
// Depends on bps_pkg for the request and response types.
module bps_alu (
	input  bps_pkg::alu_req_t req,
	output bps_pkg::alu_rsp_t rsp
);
	import bps_pkg::*;

	logic signed [MA_W-1:0]   a_s;
	logic signed [MB_W-1:0]   b_s;
	logic signed [PROD_W-1:0] prod;
	logic [REM_W:0]           diff_ext;

	assign a_s = req.mul_a;
	assign b_s = req.mul_b;

	always_comb begin
		prod     = '0;
		diff_ext = '0;
		case (req.op)
			ALU_MUL: begin
				prod = a_s * b_s;
			end
			ALU_SUB: begin
				diff_ext = {1'b0, req.sub_a} - {1'b0, req.sub_b};
			end
			default: begin
				prod     = '0;
				diff_ext = '0;
			end
		endcase
	end

	assign rsp.prod   = prod;
	assign rsp.diff   = diff_ext[REM_W-1:0];
	assign rsp.borrow = diff_ext[REM_W];

endmodule

>>> rtl/bps_ctrl.sv
// Sequencer and working registers: sums of products, normalization, square
// root, division and the power loop, all through bps_alu. Depends on bps_pkg.
module bps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  bps_pkg::core_ctl_t  ctl,
	output bps_pkg::core_sts_t  sts,
	input  bps_pkg::half_t      h_vec [3],
	input  bps_pkg::comp_t      n_vec [3],
	input  bps_pkg::expo_t      expo,
	output bps_pkg::alu_req_t   alu_req,
	input  bps_pkg::alu_rsp_t   alu_rsp
);
	import bps_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SQR    = 9'b000000010,
		ST_CHECK  = 9'b000000100,
		ST_NORM   = 9'b000001000,
		ST_SQRT   = 9'b000010000,
		ST_DIVCHK = 9'b000100000,
		ST_DIV    = 9'b001000000,
		ST_POW    = 9'b010000000,
		ST_FIN    = 9'b100000000
	} state_t;

	localparam int SH_L     = (E_OFF > 0) ? E_OFF : 0;
	localparam int SH_R     = (E_OFF < 0) ? -E_OFF : 0;
	localparam int SQR_LAST = 5;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ph_q;
	logic [NORM_W-1:0]       s_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [DV_W-1:0]         dvd_q;
	logic                    ovf_q;
	logic [ROOT_W-1:0]       root_q;
	logic [ROOT_W:0]         rem_q;
	q15_t                    low_q;
	q15_t                    base_q;
	q15_t                    acc_q;
	expo_t                   exp_q;

	logic [1:0]              idx;
	logic [DV_W+SH_L-1:0]    dvd_ext;
	logic [NORM_W-1:0]       dividend;
	logic                    div_top_zero;
	logic [ROOT_W-1:0]       div_hi;
	logic [REM_W-1:0]        sq_rem;
	logic [ROOT_W:0]         div_rem;
	q15_t                    quot;
	logic [PROD_W-1:0]       rnd;
	q15_t                    mul_q;
	logic                    s_top_zero;
	logic                    no_light;

	assign idx          = cnt_q[2:1];
	assign dvd_ext      = (DV_W + SH_L)'(dvd_q);
	assign dividend     = NORM_W'((dvd_ext << SH_L) >> SH_R);
	assign div_top_zero = (dividend[NORM_W-1:Q_W+ROOT_W] == '0);
	assign div_hi       = dividend[Q_W+ROOT_W-1:Q_W];
	assign sq_rem       = {rem_q, s_q[NORM_W-1 -: 2]};
	assign div_rem      = {rem_q[ROOT_W-1:0], low_q[Q_W-1]};
	assign quot         = {low_q[Q_W-2:0], !alu_rsp.borrow};
	assign rnd          = $unsigned(alu_rsp.prod) + PROD_W'(ROUND_Q15);
	assign mul_q        = Q_W'(rnd >> Q15_SHIFT);
	assign s_top_zero   = (s_q[NORM_W-1 -: 2] == 2'b00);
	assign no_light     = (s_q == '0) || dot_q[DOT_W-1] || (dot_q == '0);

	always_comb begin
		alu_req    = '0;
		alu_req.op = ALU_SUB;
		case (state_q)
			ST_SQR: begin
				alu_req.op    = ALU_MUL;
				alu_req.mul_a = MA_W'(h_vec[idx]);
				alu_req.mul_b = cnt_q[0] ? MB_W'(n_vec[idx]) : MB_W'(h_vec[idx]);
			end
			ST_SQRT: begin
				alu_req.sub_a = sq_rem;
				alu_req.sub_b = REM_W'({root_q, 2'b01});
			end
			ST_DIVCHK: begin
				alu_req.sub_a = REM_W'(div_hi);
				alu_req.sub_b = REM_W'(root_q);
			end
			ST_DIV: begin
				alu_req.sub_a = REM_W'(div_rem);
				alu_req.sub_b = REM_W'(root_q);
			end
			ST_POW: begin
				alu_req.op    = ALU_MUL;
				alu_req.mul_a = (!ph_q && exp_q[0]) ? MA_W'(acc_q) : MA_W'(base_q);
				alu_req.mul_b = MB_W'(base_q);
			end
			default: begin
				alu_req.op = ALU_SUB;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ph_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_SQR;
						cnt_q   <= '0;
					end
				end
				ST_SQR: begin
					if (cnt_q == CNT_W'(SQR_LAST)) begin
						state_q <= ST_CHECK;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CHECK: begin
					state_q <= no_light ? ST_FIN : ST_NORM;
				end
				ST_NORM: begin
					if (!s_top_zero) begin
						state_q <= ovf_q ? ST_POW : ST_SQRT;
						cnt_q   <= '0;
						ph_q    <= 1'b0;
					end
				end
				ST_SQRT: begin
					if (cnt_q == CNT_W'(ROOT_W - 1)) begin
						state_q <= ST_DIVCHK;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIVCHK: begin
					state_q <= (!div_top_zero || !alu_rsp.borrow) ? ST_POW : ST_DIV;
					cnt_q   <= '0;
					ph_q    <= 1'b0;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(Q_W - 1)) begin
						state_q <= ST_POW;
						cnt_q   <= '0;
						ph_q    <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_POW: begin
					if (ph_q) begin
						ph_q <= 1'b0;
					end else if (exp_q == '0) begin
						state_q <= ST_FIN;
					end else if (exp_q[0]) begin
						ph_q <= 1'b1;
					end
				end
				ST_FIN: begin
					if (ctl.res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				s_q   <= '0;
				dot_q <= '0;
				acc_q <= ONE_Q15;
			end
			ST_SQR: begin
				if (cnt_q[0]) begin
					dot_q <= dot_q + DOT_W'(alu_rsp.prod);
				end else begin
					s_q <= s_q + NORM_W'(alu_rsp.prod);
				end
			end
			ST_CHECK: begin
				dvd_q <= DV_W'($unsigned(dot_q));
				ovf_q <= 1'b0;
				exp_q <= expo;
				if (no_light) begin
					acc_q <= '0;
				end
			end
			ST_NORM: begin
				if (s_top_zero) begin
					s_q   <= s_q << 2;
					dvd_q <= dvd_q << 1;
					ovf_q <= ovf_q | dvd_q[DV_W-1];
				end else begin
					rem_q  <= '0;
					root_q <= '0;
					base_q <= ONE_Q15;
				end
			end
			ST_SQRT: begin
				s_q    <= s_q << 2;
				root_q <= {root_q[ROOT_W-2:0], !alu_rsp.borrow};
				rem_q  <= alu_rsp.borrow ? sq_rem[ROOT_W:0] : alu_rsp.diff[ROOT_W:0];
			end
			ST_DIVCHK: begin
				rem_q  <= {1'b0, div_hi};
				low_q  <= dividend[Q_W-1:0];
				base_q <= ONE_Q15;
			end
			ST_DIV: begin
				rem_q <= alu_rsp.borrow ? div_rem : alu_rsp.diff[ROOT_W:0];
				low_q <= quot;
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					base_q <= (quot > ONE_Q15) ? ONE_Q15 : quot;
				end
			end
			ST_POW: begin
				if (ph_q) begin
					base_q <= mul_q;
					exp_q  <= exp_q >> 1;
				end else if (exp_q != '0) begin
					if (exp_q[0]) begin
						acc_q <= mul_q;
					end else begin
						base_q <= mul_q;
						exp_q  <= exp_q >> 1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.idle      = (state_q == ST_IDLE);
	assign sts.res_valid = (state_q == ST_FIN);
	assign sts.res       = acc_q;

endmodule

>>> bench/blinn_phong_specular_term_test.sv
// Testbench for blinn_phong_specular_term: directed and random shading items with
// random idling on both channels, checked against a predictor of the specular term.
// Depends on bps_pkg and blinn_phong_specular_term.
`timescale 1ns / 100ps

module blinn_phong_specular_term_test;
	import bps_pkg::*;

	typedef struct packed {
		comp_t eye_x;
		comp_t eye_y;
		comp_t eye_z;
		comp_t light_x;
		comp_t light_y;
		comp_t light_z;
		comp_t normal_x;
		comp_t normal_y;
		comp_t normal_z;
		expo_t shininess;
	} shade_item_t;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 150;
	localparam int RANDOM_ITEMS    = 1300;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	comp_t eye_x = '0;
	comp_t eye_y = '0;
	comp_t eye_z = '0;
	comp_t light_x = '0;
	comp_t light_y = '0;
	comp_t light_z = '0;
	comp_t normal_x = '0;
	comp_t normal_y = '0;
	comp_t normal_z = '0;
	expo_t shininess = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	q15_t  specular;

	q15_t expected_specular[$];
	int   mismatches = 0;
	bit   steady_flow = 1'b0;
	bit   hold_off_req = 1'b0;

	blinn_phong_specular_term u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.eye_x     (eye_x),
		.eye_y     (eye_y),
		.eye_z     (eye_z),
		.light_x   (light_x),
		.light_y   (light_y),
		.light_z   (light_z),
		.normal_x  (normal_x),
		.normal_y  (normal_y),
		.normal_z  (normal_z),
		.shininess (shininess),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.specular  (specular)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint half_diff(comp_t l, comp_t e);
		longint d;
		longint m;
		d = longint'(l) - longint'(e);
		m = (d < 0) ? -d : d;
		m = m >>> H_SHIFT;
		return (d < 0) ? -m : m;
	endfunction

	function automatic longint unsigned q15_product(longint unsigned a, longint unsigned b);
		return (a * b + ROUND_Q15) >> Q15_SHIFT;
	endfunction

	function automatic q15_t predict_specular(shade_item_t it);
		longint hx, hy, hz, dotp;
		longint unsigned sq, root, rem, bitv, ud, cosine, base, acc;
		int norm_steps, e_sh, i;
		hx = half_diff(it.light_x, it.eye_x);
		hy = half_diff(it.light_y, it.eye_y);
		hz = half_diff(it.light_z, it.eye_z);
		sq = hx * hx + hy * hy + hz * hz;
		dotp = hx * longint'(it.normal_x) + hy * longint'(it.normal_y)
			+ hz * longint'(it.normal_z);
		if (sq == 0 || dotp <= 0) begin
			return '0;
		end
		norm_steps = 0;
		while (sq < (64'd1 << 60)) begin
			sq = sq << 2;
			norm_steps++;
		end
		root = 0;
		rem = sq;
		bitv = 64'd1 << 62;
		while (bitv > rem) begin
			bitv = bitv >> 2;
		end
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		ud = dotp;
		e_sh = norm_steps + 15 - (COMPONENT_BITS - 2);
		if (e_sh >= 0) begin
			if ((ud >> (62 - e_sh)) != 0) begin
				cosine = 32768;
			end else begin
				cosine = (ud << e_sh) / root;
			end
		end else begin
			cosine = ud / (root << (-e_sh));
		end
		if (cosine > 32768) begin
			cosine = 32768;
		end
		base = cosine;
		acc = 32768;
		for (i = 0; i < EXPONENT_BITS; i++) begin
			if (it.shininess[i]) begin
				acc = q15_product(acc, base);
			end
			base = q15_product(base, base);
		end
		return q15_t'(acc);
	endfunction

	function automatic int idle_cycles();
		if ($urandom_range(0, 15) == 0) begin
			return $urandom_range(20, 80);
		end
		return $urandom_range(1, 3);
	endfunction

	function automatic shade_item_t make_item(int ex, int ey, int ez, int lx, int ly, int lz,
			int nx, int ny, int nz, int sh);
		shade_item_t it;
		it.eye_x = comp_t'(ex);
		it.eye_y = comp_t'(ey);
		it.eye_z = comp_t'(ez);
		it.light_x = comp_t'(lx);
		it.light_y = comp_t'(ly);
		it.light_z = comp_t'(lz);
		it.normal_x = comp_t'(nx);
		it.normal_y = comp_t'(ny);
		it.normal_z = comp_t'(nz);
		it.shininess = expo_t'(sh);
		return it;
	endfunction

	function automatic void random_dir(output real x, output real y, output real z);
		real len;
		do begin
			x = $itor($urandom_range(0, 2000)) - 1000.0;
			y = $itor($urandom_range(0, 2000)) - 1000.0;
			z = $itor($urandom_range(0, 2000)) - 1000.0;
			len = $sqrt(x * x + y * y + z * z);
		end while (len < 1.0);
		x = x / len;
		y = y / len;
		z = z / len;
	endfunction

	function automatic expo_t random_shininess();
		case ($urandom_range(0, 3))
			0: begin
				return expo_t'($urandom_range(0, 8));
			end
			1: begin
				return expo_t'($urandom_range(0, 64));
			end
			2: begin
				return expo_t'($urandom_range(0, 255));
			end
			default: begin
				return expo_t'(255 - $urandom_range(0, 3));
			end
		endcase
	endfunction

	// Unit eye and light directions, with a normal that leans toward the half
	// vector by a random amount so that most cosines are positive and many
	// are close to one.
	function automatic shade_item_t shading_item();
		shade_item_t it;
		real ex, ey, ez, lx, ly, lz, rx, ry, rz, nx, ny, nz, jit, len;
		random_dir(ex, ey, ez);
		random_dir(lx, ly, lz);
		random_dir(rx, ry, rz);
		case ($urandom_range(0, 3))
			0: jit = 0.0;
			1: jit = 0.05;
			2: jit = 0.3;
			default: jit = 1.5;
		endcase
		nx = (lx - ex) + jit * rx;
		ny = (ly - ey) + jit * ry;
		nz = (lz - ez) + jit * rz;
		len = $sqrt(nx * nx + ny * ny + nz * nz);
		if (len < 0.001) begin
			nx = rx;
			ny = ry;
			nz = rz;
			len = 1.0;
		end
		it.eye_x = comp_t'($rtoi(ex * 16384.0));
		it.eye_y = comp_t'($rtoi(ey * 16384.0));
		it.eye_z = comp_t'($rtoi(ez * 16384.0));
		it.light_x = comp_t'($rtoi(lx * 16384.0));
		it.light_y = comp_t'($rtoi(ly * 16384.0));
		it.light_z = comp_t'($rtoi(lz * 16384.0));
		it.normal_x = comp_t'($rtoi(nx / len * 16384.0));
		it.normal_y = comp_t'($rtoi(ny / len * 16384.0));
		it.normal_z = comp_t'($rtoi(nz / len * 16384.0));
		it.shininess = random_shininess();
		return it;
	endfunction

	function automatic shade_item_t noise_item();
		return make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
	endfunction

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= 100) begin
			$display("mismatch %0d at %0t: %s, expected %0d, got %0d",
				mismatches, $realtime, what, want, got);
		end
	endtask

	task automatic send_item(input shade_item_t it);
		in_valid <= 1'b1;
		eye_x <= it.eye_x;
		eye_y <= it.eye_y;
		eye_z <= it.eye_z;
		light_x <= it.light_x;
		light_y <= it.light_y;
		light_z <= it.light_z;
		normal_x <= it.normal_x;
		normal_y <= it.normal_y;
		normal_z <= it.normal_z;
		shininess <= it.shininess;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		expected_specular.push_back(predict_specular(it));
		if (!steady_flow && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (idle_cycles()) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_specular.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_directed();
		// Zero half vector, from all-zero inputs and from equal eye and light.
		send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(1000, 2000, -3000, 1000, 2000, -3000, 0, 0, 16384, 5));
		// Half vector along the normal: cosine exactly one.
		send_item(make_item(0, 0, -16384, 0, 0, 16384, 0, 0, 16384, 1));
		send_item(make_item(0, 0, -16384, 0, 0, 16384, 0, 0, 16384, 0));
		send_item(make_item(0, 0, -16384, 0, 0, 16384, 0, 0, 16384, 255));
		// Negative cosine, with and without an exponent.
		send_item(make_item(0, 0, -16384, 0, 0, 16384, 0, 0, -16384, 3));
		send_item(make_item(0, 0, -16384, 0, 0, 16384, 0, 0, -16384, 0));
		// Normal perpendicular to the half vector.
		send_item(make_item(0, 0, -16384, 0, 0, 16384, 16384, 0, 0, 0));
		// Cosine of one over root two at several exponents.
		send_item(make_item(-16384, 0, 0, 0, 16384, 0, 16384, 0, 0, 1));
		send_item(make_item(-16384, 0, 0, 0, 16384, 0, 16384, 0, 0, 2));
		send_item(make_item(-16384, 0, 0, 0, 16384, 0, 16384, 0, 0, 8));
		send_item(make_item(-16384, 0, 0, 0, 16384, 0, 16384, 0, 0, 255));
		// Field extremes; an over-long normal saturates the cosine.
		send_item(make_item(-32768, -32768, -32768, 32767, 32767, 32767,
			32767, 32767, 32767, 255));
		send_item(make_item(32767, 32767, 32767, -32768, -32768, -32768,
			-32768, -32768, -32768, 170));
		send_item(make_item(32767, 32767, 32767, -32768, -32768, -32768,
			-32768, -32768, -32768, 85));
		send_item(make_item(32767, -32768, 32767, -32768, 32767, -32768,
			32767, -32768, 32767, 0));
		// Smallest half vectors.
		send_item(make_item(0, 0, 0, 1, 0, 0, 1, 0, 0, 1));
		send_item(make_item(0, 0, 0, 1, 0, 0, 16384, 0, 0, 1));
		send_item(make_item(0, 0, 1, 0, 0, 0, 0, 0, -1, 200));
		send_item(make_item(0, 0, 0, 1, 1, 1, 16384, 16384, -16383, 4));
		// Cosine just below one.
		send_item(make_item(0, 0, 0, 16384, 40, 0, 16384, 0, 0, 255));
		send_item(make_item(0, 0, 0, 16384, 40, 0, 16384, 0, 0, 16));
		wait_drained();
	endtask

	// Receiver holds off long enough for the block to fill and drop in_ready.
	task automatic test_full_stall();
		int i;
		hold_off_req = 1'b1;
		steady_flow = 1'b1;
		for (i = 0; i < 8; i++) begin
			send_item(shading_item());
		end
		steady_flow = 1'b0;
	endtask

	// Sender pauses until every result has come back, then resumes.
	task automatic test_drain_pause();
		int i;
		for (i = 0; i < 6; i++) begin
			send_item(shading_item());
		end
		wait_drained();
		for (i = 0; i < 6; i++) begin
			send_item(noise_item());
		end
	endtask

	task automatic test_random_shading(int count);
		int i;
		for (i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				steady_flow = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 9) < 7) begin
				send_item(shading_item());
			end else begin
				send_item(noise_item());
			end
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		int stall;
		stall = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = HOLD_OFF_CYCLES;
				out_ready <= 1'b0;
			end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
				stall = idle_cycles() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_specular.size() == 0) begin
				report_mismatch("item with no expectation", 0, specular);
			end else begin
				q15_t want;
				want = expected_specular.pop_front();
				if (specular !== want) begin
					report_mismatch("specular", want, specular);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_stall();
		test_drain_pause();
		test_random_shading(RANDOM_ITEMS);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_specular.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/bps_pkg.sv
rtl/bps_alu.sv
rtl/bps_ctrl.sv
rtl/blinn_phong_specular_term.sv
bench/blinn_phong_specular_term_test.sv
